[rtl/pafp_pkg.sv]
`timescale 1ns / 1ps
package pafp_pkg;
    localparam int MEM_UNITS_DEF   = 512;
    localparam int MAX_SEGS_DEF    = 64;
    localparam int OWNER_COUNT_DEF = 256;
    localparam int SIZE_W  = 17;
    localparam int OWNER_W = 8;
    localparam int UNITS_W = 10;
    localparam int OFF_W   = 9;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOOWNER = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic       REQ_ALLOC = 1'b0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_DECIDE,
        S_SHIFT_UP,
        S_WRITE,
        S_FREE_NEXT,
        S_FREE_PREV,
        S_SHIFT_DN,
        S_DONE
    } state_t;
endpackage

[rtl/pafp_table.sv]
`timescale 1ns / 1ps
// partition table memory: one write port, one registered read port
module pafp_table #(
    parameter int MAX_SEGS = pafp_pkg::MAX_SEGS_DEF,
    parameter int IDX_W    = $clog2(MAX_SEGS)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [IDX_W-1:0]             waddr,
    input  logic [pafp_pkg::SIZE_W-1:0]  wsize,
    input  logic                         wused,
    input  logic [pafp_pkg::OWNER_W-1:0] wowner,
    input  logic [IDX_W-1:0]             raddr,
    output logic [pafp_pkg::SIZE_W-1:0]  rsize,
    output logic                         rused,
    output logic [pafp_pkg::OWNER_W-1:0] rowner
);
    localparam int ENT_W = pafp_pkg::SIZE_W + 1 + pafp_pkg::OWNER_W;
    logic [ENT_W-1:0] mem [MAX_SEGS];
    logic [ENT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wsize, wused, wowner};
        end
        rdata_reg <= mem[raddr];
    end

    assign {rsize, rused, rowner} = rdata_reg;
endmodule

[rtl/partition_allocator_fit_policies.sv]
`timescale 1ns / 1ps
// operation: a request scans the table entry by entry (read in S_SCAN, checked in S_SCAN_WAIT),
//   then moves entries one at a time, each read and then written, to split or merge
// throughput: one request at a time; req_stall stays high until the result is taken and the
//   next request can be taken in the cycle after that
// reset: rst_n async active low; table holds one free partition of MEM_UNITS units,
//   a flag makes entry 0 read as MEM_UNITS free until it is first written
module partition_allocator_fit_policies #(
    parameter int MEM_UNITS   = pafp_pkg::MEM_UNITS_DEF,
    parameter int MAX_SEGS    = pafp_pkg::MAX_SEGS_DEF,
    parameter int OWNER_COUNT = pafp_pkg::OWNER_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       req_type,
    input  logic [1:0] fit_policy,
    input  logic [7:0] owner_id,
    input  logic [9:0] req_units,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [1:0] status,
    output logic [8:0] start_offset,
    output logic [9:0] part_units
);
    localparam int IDX_W = $clog2(MAX_SEGS);
    localparam int CNT_W = $clog2(MAX_SEGS + 1);
    localparam int SW    = pafp_pkg::SIZE_W;
    localparam int OW    = pafp_pkg::OWNER_W;

    pafp_pkg::state_t state_reg, state_next;

    // request latch
    logic          typ_reg;
    logic [1:0]    pol_reg;
    logic [OW-1:0] own_reg;
    logic [9:0]    units_reg;

    // scan bookkeeping
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [SW-1:0]    off_reg, off_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] pick_reg, pick_next;
    logic [SW-1:0]    poff_reg, poff_next;
    logic [SW-1:0]    best_reg, best_next;
    logic [SW-1:0]    psize_reg, psize_next;
    logic [SW-1:0]    nsize_reg, nsize_next;
    logic             e0_init_reg, e0_init_next;

    // shift pointer and flag for the pending read of the entry being moved
    logic [CNT_W-1:0] sp_reg, sp_next;
    logic             mv_rd_reg, mv_rd_next;

    logic [1:0]       st_reg, st_next;
    logic [8:0]       ro_reg, ro_next;
    logic [9:0]       ru_reg, ru_next;

    // memory ports
    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [SW-1:0]    wsize, rsize_m, rsize;
    logic             wused, rused_m, rused;
    logic [OW-1:0]    wowner, rowner;
    logic [IDX_W-1:0] rd_addr_reg;

    pafp_table #(.MAX_SEGS(MAX_SEGS), .IDX_W(IDX_W)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wsize(wsize), .wused(wused),
        .wowner(wowner), .raddr(raddr), .rsize(rsize_m), .rused(rused_m),
        .rowner(rowner)
    );

    // entry 0 reads as one free partition until it is first written
    assign rsize = (!e0_init_reg && rd_addr_reg == '0) ? SW'(MEM_UNITS) : rsize_m;
    assign rused = (!e0_init_reg && rd_addr_reg == '0) ? 1'b0 : rused_m;

    // owner reduction as a constant lookup over all 256 ids
    function automatic logic [256*OW-1:0] own_table();
        logic [256*OW-1:0] t;
        for (int k = 0; k < 256; k++)
        begin
            t[k*OW +: OW] = OW'(k % OWNER_COUNT);
        end
        return t;
    endfunction

    localparam logic [256*OW-1:0] OWN_TBL = own_table();

    logic [OW-1:0] own_mod;
    assign own_mod = OWN_TBL[OW*int'(owner_id) +: OW];

    assign req_stall = (state_reg != pafp_pkg::S_IDLE);
    assign rsp_valid = (state_reg == pafp_pkg::S_DONE);
    assign status       = st_reg;
    assign start_offset = ro_reg;
    assign part_units   = ru_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pafp_pkg::S_IDLE;
            cnt_reg     <= CNT_W'(1);
            e0_init_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            e0_init_reg <= e0_init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == pafp_pkg::S_IDLE && req_valid)
        begin
            typ_reg   <= req_type;
            pol_reg   <= fit_policy;
            own_reg   <= own_mod;
            units_reg <= req_units;
        end
        idx_reg     <= idx_next;
        off_reg     <= off_next;
        found_reg   <= found_next;
        pick_reg    <= pick_next;
        poff_reg    <= poff_next;
        best_reg    <= best_next;
        psize_reg   <= psize_next;
        nsize_reg   <= nsize_next;
        sp_reg      <= sp_next;
        mv_rd_reg   <= mv_rd_next;
        st_reg      <= st_next;
        ro_reg      <= ro_next;
        ru_reg      <= ru_next;
        rd_addr_reg <= raddr;
    end

    // next state
    always_comb
    begin
        logic avail;
        avail = !rused && units_reg != '0 && rsize >= SW'(units_reg);
        state_next = state_reg;
        case (state_reg)
            pafp_pkg::S_IDLE:
                if (req_valid) state_next = pafp_pkg::S_SCAN;
            pafp_pkg::S_SCAN:
                state_next = (idx_reg >= cnt_reg) ? pafp_pkg::S_DECIDE
                                                  : pafp_pkg::S_SCAN_WAIT;
            pafp_pkg::S_SCAN_WAIT:
            begin
                state_next = pafp_pkg::S_SCAN;
                if (typ_reg == pafp_pkg::REQ_ALLOC)
                begin
                    if (avail && pol_reg != pafp_pkg::POL_BEST
                        && pol_reg != pafp_pkg::POL_WORST)
                        state_next = pafp_pkg::S_DECIDE;
                end
                else if (rused && rowner == own_reg)
                    state_next = pafp_pkg::S_DECIDE;
            end
            pafp_pkg::S_DECIDE:
            begin
                if (!found_reg)
                    state_next = pafp_pkg::S_DONE;
                else if (typ_reg == pafp_pkg::REQ_ALLOC)
                begin
                    if (psize_reg > SW'(units_reg))
                        state_next = (cnt_reg >= CNT_W'(MAX_SEGS)) ? pafp_pkg::S_DONE
                                                                   : pafp_pkg::S_SHIFT_UP;
                    else
                        state_next = pafp_pkg::S_WRITE;
                end
                else
                    state_next = pafp_pkg::S_FREE_NEXT;
            end
            pafp_pkg::S_SHIFT_UP:
                if (sp_reg <= CNT_W'(pick_reg) + CNT_W'(1) && !mv_rd_reg)
                    state_next = pafp_pkg::S_WRITE;
            pafp_pkg::S_WRITE:
                state_next = pafp_pkg::S_DONE;
            pafp_pkg::S_FREE_NEXT:
                if (mv_rd_reg) state_next = pafp_pkg::S_FREE_PREV;
            pafp_pkg::S_FREE_PREV:
                if (mv_rd_reg) state_next = pafp_pkg::S_SHIFT_DN;
            pafp_pkg::S_SHIFT_DN:
                if (sp_reg >= cnt_reg && !mv_rd_reg) state_next = pafp_pkg::S_DONE;
            pafp_pkg::S_DONE:
                if (!rsp_stall) state_next = pafp_pkg::S_IDLE;
            default:
                state_next = pafp_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        logic          avail, take;
        logic [SW-1:0] rem;
        avail = !rused && units_reg != '0 && rsize >= SW'(units_reg);
        rem   = rsize - SW'(units_reg);
        take  = 1'b0;

        cnt_next     = cnt_reg;
        e0_init_next = e0_init_reg;
        idx_next     = idx_reg;
        off_next     = off_reg;
        found_next   = found_reg;
        pick_next    = pick_reg;
        poff_next    = poff_reg;
        best_next    = best_reg;
        psize_next   = psize_reg;
        nsize_next   = nsize_reg;
        sp_next      = sp_reg;
        mv_rd_next   = mv_rd_reg;
        st_next      = st_reg;
        ro_next      = ro_reg;
        ru_next      = ru_reg;
        we     = 1'b0;
        waddr  = '0;
        wsize  = '0;
        wused  = 1'b0;
        wowner = '0;
        raddr  = idx_reg[IDX_W-1:0];

        case (state_reg)
            pafp_pkg::S_IDLE:
            begin
                idx_next   = '0;
                off_next   = '0;
                found_next = 1'b0;
                mv_rd_next = 1'b0;
                raddr      = '0;
            end
            pafp_pkg::S_SCAN:
                raddr = idx_reg[IDX_W-1:0];
            pafp_pkg::S_SCAN_WAIT:
            begin
                if (typ_reg == pafp_pkg::REQ_ALLOC)
                begin
                    if (avail)
                    begin
                        if (pol_reg == pafp_pkg::POL_BEST)
                            take = !found_reg || rem <= best_reg;
                        else if (pol_reg == pafp_pkg::POL_WORST)
                            take = !found_reg || rsize > best_reg;
                        else
                            take = !found_reg;
                    end
                    if (take)
                        best_next = (pol_reg == pafp_pkg::POL_BEST) ? rem : rsize;
                end
                else
                    take = rused && rowner == own_reg;
                if (take)
                begin
                    found_next = 1'b1;
                    pick_next  = idx_reg[IDX_W-1:0];
                    poff_next  = off_reg;
                    psize_next = rsize;
                end
                off_next = off_reg + rsize;
                idx_next = idx_reg + CNT_W'(1);
            end
            pafp_pkg::S_DECIDE:
            begin
                st_next = pafp_pkg::ST_OK;
                ro_next = poff_reg[8:0];
                ru_next = (typ_reg == pafp_pkg::REQ_ALLOC) ? units_reg : psize_reg[9:0];
                if (!found_reg)
                    st_next = (typ_reg == pafp_pkg::REQ_ALLOC) ? pafp_pkg::ST_NOFIT
                                                               : pafp_pkg::ST_NOOWNER;
                else if (typ_reg == pafp_pkg::REQ_ALLOC && psize_reg > SW'(units_reg)
                         && cnt_reg >= CNT_W'(MAX_SEGS))
                    st_next = pafp_pkg::ST_FULL;
                if (st_next != pafp_pkg::ST_OK)
                begin
                    ro_next = '0;
                    ru_next = '0;
                end
                // shift from the end toward pick+1
                sp_next    = cnt_reg;
                mv_rd_next = 1'b0;
                if (typ_reg != pafp_pkg::REQ_ALLOC)
                    raddr = pick_reg + IDX_W'(1);
            end
            pafp_pkg::S_SHIFT_UP:
            begin
                // move entry sp-1 to sp, read then write
                if (!mv_rd_reg)
                begin
                    if (sp_reg > CNT_W'(pick_reg) + CNT_W'(1))
                    begin
                        raddr      = IDX_W'(sp_reg - CNT_W'(1));
                        mv_rd_next = 1'b1;
                    end
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = sp_reg[IDX_W-1:0];
                    wsize      = rsize;
                    wused      = rused;
                    wowner     = rowner;
                    sp_next    = sp_reg - CNT_W'(1);
                    mv_rd_next = 1'b0;
                end
            end
            pafp_pkg::S_WRITE:
            begin
                we     = 1'b1;
                waddr  = pick_reg;
                wsize  = SW'(units_reg);
                wused  = 1'b1;
                wowner = own_reg;
                if (pick_reg == '0) e0_init_next = 1'b1;
                if (psize_reg > SW'(units_reg))
                begin
                    // remainder entry written in the following cycle, in S_DONE
                    nsize_next = psize_reg - SW'(units_reg);
                    cnt_next   = cnt_reg + CNT_W'(1);
                end
            end
            pafp_pkg::S_FREE_NEXT:
            begin
                // first cycle: read of pick+1 issued in decide arrives now
                if (!mv_rd_reg)
                begin
                    nsize_next = psize_reg;
                    sp_next    = '0; // count of drops
                    if (CNT_W'(pick_reg) + CNT_W'(1) < cnt_reg && !rused)
                    begin
                        nsize_next = psize_reg + rsize;
                        sp_next    = CNT_W'(1);
                    end
                    raddr      = pick_reg - IDX_W'(1);
                    mv_rd_next = 1'b1;
                end
                else
                begin
                    // keep pick-1 on the read port for the next cycle
                    raddr      = pick_reg - IDX_W'(1);
                    mv_rd_next = 1'b1;
                end
            end
            pafp_pkg::S_FREE_PREV:
            begin
                if (mv_rd_reg)
                begin
                    // best_reg: destination index of merged entry
                    best_next = SW'(pick_reg);
                    if (pick_reg != '0 && !rused)
                    begin
                        best_next  = SW'(pick_reg) - SW'(1);
                        nsize_next = nsize_reg + rsize;
                        sp_next    = sp_reg + CNT_W'(1);
                    end
                    we     = 1'b1;
                    waddr  = best_next[IDX_W-1:0];
                    wsize  = best_next[IDX_W-1:0] == pick_reg ? nsize_reg
                                                              : nsize_reg + rsize;
                    wused  = 1'b0;
                    wowner = '0;
                    if (best_next[IDX_W-1:0] == '0) e0_init_next = 1'b1;
                    // psize_reg now holds the number of dropped entries
                    psize_next = SW'(sp_next);
                    cnt_next   = cnt_reg - sp_next;
                    // copy pointer: source starts at dst+1+drops
                    sp_next    = CNT_W'(best_next[IDX_W-1:0]) + CNT_W'(1);
                    mv_rd_next = 1'b0;
                end
            end
            pafp_pkg::S_SHIFT_DN:
            begin
                // move entry sp+drops to sp, until sp reaches the new count
                if (!mv_rd_reg)
                begin
                    if (sp_reg < cnt_reg)
                    begin
                        raddr      = IDX_W'(sp_reg + CNT_W'(psize_reg));
                        mv_rd_next = 1'b1;
                    end
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = sp_reg[IDX_W-1:0];
                    wsize      = rsize;
                    wused      = rused;
                    wowner     = rowner;
                    sp_next    = sp_reg + CNT_W'(1);
                    mv_rd_next = 1'b0;
                end
            end
            pafp_pkg::S_DONE:
            begin
                // write remainder of a split once (flag via found_reg)
                if (found_reg && typ_reg == pafp_pkg::REQ_ALLOC && st_reg == pafp_pkg::ST_OK
                    && psize_reg > SW'(units_reg))
                begin
                    we         = 1'b1;
                    waddr      = pick_reg + IDX_W'(1);
                    wsize      = nsize_reg;
                    wused      = 1'b0;
                    wowner     = '0;
                    found_next = 1'b0;
                end
            end
            default: ;
        endcase
    end
endmodule

[rtl/pafp_checker.sv]
`timescale 1ns / 1ps
module pafp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_stall,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic [1:0] status,
    input logic [8:0] start_offset,
    input logic [9:0] part_units
);
    // a request is never taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request accepted while result pending");

    // errors carry zero size and offset
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != pafp_pkg::ST_OK |-> part_units == '0 && start_offset == '0)
        else $error("error result with nonzero payload");

    // an accepted request leads to a busy block
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("not busy after request");

    // a stalled result stays valid with a stable status
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status))
        else $error("result changed under stall");
endmodule

bind partition_allocator_fit_policies pafp_checker u_pafp_checker (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status),
    .start_offset(start_offset), .part_units(part_units)
);
